// ===== hdl/ssq_pkg.sv =====
// Package for the sorted size queue: field widths, operation and status codes,
// and the slot and cell command types shared by the cells and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssq_pkg;

  localparam int FUNC_W   = 2;
  localparam int SIZE_W   = 48;
  localparam int INDEX_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT    = 2'd0,
    FUNC_POP_FRONT = 2'd1,
    FUNC_POP_BACK  = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // One stored entry with its occupancy flag
  typedef struct packed {
    logic               valid;
    logic [SIZE_W-1:0]  size;
    logic [INDEX_W-1:0] index;
  } slot_t;

  // Broadcast to every cell; at most one bit is set
  typedef struct packed {
    logic insert;
    logic pop_front;
    logic pop_back;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/ssq_req_if.sv =====
// Request channel of the sorted size queue: valid/ready plus operation payload.
// Depends on ssq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ssq_req_if
  import ssq_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [SIZE_W-1:0]  entry_size;
  logic [INDEX_W-1:0] entry_index;

  modport source (output valid, output func, output entry_size, output entry_index,
                  input ready);
  modport sink   (input valid, input func, input entry_size, input entry_index,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/ssq_rsp_if.sv =====
// Response channel of the sorted size queue: valid/ready plus result payload.
// Depends on ssq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ssq_rsp_if
  import ssq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                popped;
  logic [SIZE_W-1:0]   out_size;
  logic [INDEX_W-1:0]  out_index;
  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, output popped, output out_size, output out_index,
                  output status, output occupancy, input ready);
  modport sink   (input valid, input popped, input out_size, input out_index,
                  input status, input occupancy, output ready);
endinterface

`default_nettype wire

// ===== hdl/ssq_cell.sv =====
// One cell of the sorted chain: holds a slot and moves it to or from its
// neighbours on insert and pop. Depends on ssq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssq_cell
  import ssq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cell_cmd_t          cmd,
  input  wire logic [SIZE_W-1:0]  new_size,
  input  wire logic [INDEX_W-1:0] new_index,
  input  wire slot_t              prev_slot,
  input  wire logic               prev_place,
  input  wire slot_t              next_slot,
  output slot_t                   slot,
  output logic                    place,
  output logic                    last
);

  logic               load_new;
  logic               take_prev;
  logic               occupied;
  logic [SIZE_W-1:0]  stored_size;
  logic [INDEX_W-1:0] stored_index;

  assign slot = {occupied, stored_size, stored_index};

  // New entry belongs at or before this cell: empty, strictly smaller, or both zero
  assign place = !slot.valid || (new_size > slot.size)
                 || ((new_size == '0) && (slot.size == '0));
  assign last  = slot.valid && !next_slot.valid;

  assign load_new  = place && !prev_place;
  assign take_prev = place && prev_place;

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
    end else if (cmd.insert) begin
      if (load_new) begin
        occupied <= 1'b1;
      end else if (take_prev) begin
        occupied <= prev_slot.valid;
      end
    end else if (cmd.pop_front) begin
      occupied <= next_slot.valid;
    end else if (cmd.pop_back) begin
      occupied <= occupied && next_slot.valid;
    end
  end

  // Payload: load, shift back on insert, shift forward on pop-front
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (load_new) begin
        stored_size  <= new_size;
        stored_index <= new_index;
      end else if (take_prev) begin
        stored_size  <= prev_slot.size;
        stored_index <= prev_slot.index;
      end
    end else if (cmd.pop_front) begin
      stored_size  <= next_slot.size;
      stored_index <= next_slot.index;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sorted_size_queue_top.sv =====
// Sorted size queue top level: a chain of CAPACITY cells kept in descending size order.
// The response is registered and valid in the cycle after the request transfer; one operation per cycle.
// A new request is taken while the response register is empty or being drained.
// Reset (rst, synchronous) empties every cell and the response register.
// Depends on ssq_pkg, ssq_req_if, ssq_rsp_if and ssq_cell.
`timescale 1ns / 1ps
`default_nettype none

module sorted_size_queue_top
  import ssq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  ssq_req_if.sink   req,
  ssq_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  slot_t                slots [CAPACITY];
  logic [CAPACITY-1:0]  place_vec;
  logic [CAPACITY-1:0]  last_vec;
  logic [CAPACITY-1:0]  valid_vec;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic                 accept;
  logic                 full;
  logic                 empty;
  cell_cmd_t            cmd;
  slot_t                tail_slot;

  logic                 rsp_valid;
  logic                 popped;
  logic [SIZE_W-1:0]    out_size;
  logic [INDEX_W-1:0]   out_index;
  status_t              status;
  logic                 popped_next;
  logic [SIZE_W-1:0]    out_size_next;
  logic [INDEX_W-1:0]   out_index_next;
  status_t              status_next;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);

  // Chain of cells, each seeing its neighbours
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    slot_t prev_slot;
    slot_t next_slot;
    logic  prev_place;

    if (g == 0) begin : g_head
      assign prev_slot  = '0;
      assign prev_place = 1'b0;
    end else begin : g_body
      assign prev_slot  = slots[g-1];
      assign prev_place = place_vec[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign next_slot = '0;
    end else begin : g_inner
      assign next_slot = slots[g+1];
    end

    ssq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .new_size   (req.entry_size),
      .new_index  (req.entry_index),
      .prev_slot  (prev_slot),
      .prev_place (prev_place),
      .next_slot  (next_slot),
      .slot       (slots[g]),
      .place      (place_vec[g]),
      .last       (last_vec[g])
    );

    assign valid_vec[g] = slots[g].valid;
  end

  // Select the back entry through the one-hot tail mark
  always_comb begin
    tail_slot = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_slot = tail_slot | (last_vec[i] ? slots[i] : '0);
    end
  end

  // Decode the operation into a cell command and the response
  always_comb begin
    cmd            = '0;
    count_next     = count;
    popped_next    = 1'b0;
    out_size_next  = '0;
    out_index_next = '0;
    status_next    = STATUS_OK;
    unique case (func_t'(req.func))
      FUNC_INSERT: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          cmd.insert = accept;
          count_next = count + 1'b1;
        end
      end
      FUNC_POP_FRONT: begin
        if (empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          cmd.pop_front  = accept;
          count_next     = count - 1'b1;
          popped_next    = 1'b1;
          out_size_next  = slots[0].size;
          out_index_next = slots[0].index;
        end
      end
      FUNC_POP_BACK: begin
        if (empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          cmd.pop_back   = accept;
          count_next     = count - 1'b1;
          popped_next    = 1'b1;
          out_size_next  = tail_slot.size;
          out_index_next = tail_slot.index;
        end
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  // Hold the count and response valid; advance on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else if (accept) begin
      count     <= count_next;
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      popped    <= popped_next;
      out_size  <= out_size_next;
      out_index <= out_index_next;
      status    <= status_next;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.popped    = popped;
  assign rsp.out_size  = out_size;
  assign rsp.out_index = out_index;
  assign rsp.status    = status;
  assign rsp.occupancy = OCC_W'(count);

  // Count tracks the occupied cells
  assert property (@(posedge clk) disable iff (rst)
    count == CNT_W'($countones(valid_vec)))
    else $error("count differs from occupied cells");

  // Occupied cells form an unbroken run from the front
  assert property (@(posedge clk) disable iff (rst)
    ((valid_vec + 1'b1) & valid_vec) == '0)
    else $error("gap in occupied cells");

  // At most one cell is the tail
  assert property (@(posedge clk) disable iff (rst) $onehot0(last_vec))
    else $error("more than one tail cell");

  // A pop on a non-empty queue returns an entry next cycle
  assert property (@(posedge clk) disable iff (rst)
    accept && !empty && (req.func == FUNC_POP_FRONT || req.func == FUNC_POP_BACK)
    |=> rsp.valid && rsp.popped)
    else $error("pop on non-empty queue returned nothing");

endmodule

`default_nettype wire
